### design/pcxrle_pkg.sv
// shared types and constants for the pcx run-length plane decoder
// used by every module of the block; no dependencies
package pcxrle_pkg;

    // compressed stream codes
    localparam logic [7:0] MARK_BITS  = 8'hC0;
    localparam int         CNT_W      = 6;
    localparam int         DIM_W      = 17;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PLANES = 2'd2;

    // image geometry as programmed
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             three_planes;
    } t_cfg;

    // one queued pixel job: a value and how many times to write it
    typedef struct packed {
        logic [7:0]       value;
        logic [CNT_W-1:0] count;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [15:0] column;
        logic [15:0] row;
        logic [1:0]  plane;
        logic [7:0]  value;
        logic        malformed;
        logic        complete;
        logic        last;
    } t_res;

endpackage

### design/pcxrle_front.sv
// front end: accepts compressed bytes, splits markers from data and queues jobs
// depends on pcxrle_pkg
module pcxrle_front
    import pcxrle_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_dims_zero,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic             r_pending;
    logic             n_pending;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // classify the accepted byte
    always_comb begin
        n_pending = r_pending;
        n_count   = r_count;
        o_push    = 1'b0;
        o_cmd     = '{value: i_byte, count: CNT_W'(1)};
        if (i_accept && !i_dims_zero) begin
            if (r_pending) begin
                n_pending   = 1'b0;
                n_count     = '0;
                o_cmd.count = r_count;
                o_push      = (r_count != '0);
            end else if ((i_byte & MARK_BITS) == MARK_BITS) begin
                n_pending = 1'b1;
                n_count   = i_byte[CNT_W-1:0];
            end else begin
                o_push = 1'b1;
            end
        end
    end

    // run marker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
            r_count   <= '0;
        end else begin
            r_pending <= n_pending;
            r_count   <= n_count;
        end
    end

endmodule

### design/pcxrle_queue.sv
// two-entry job queue between the front end and the pixel writer
// depends on pcxrle_pkg
module pcxrle_queue
    import pcxrle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_cmd   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

### design/pcxrle_back.sv
// back end: writes queued jobs out pixel by pixel, tracks position and errors
// depends on pcxrle_pkg
module pcxrle_back
    import pcxrle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_res o_res
);

    logic [DIM_W-1:0] r_col, n_col;
    logic [DIM_W-1:0] r_row, n_row;
    logic [1:0]       r_plane, n_plane;
    logic             r_finished, n_finished;
    logic             r_error, n_error;
    logic             r_busy, n_busy;
    logic             r_bad, n_bad;
    logic [7:0]       r_val, n_val;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_ov, n_ov;
    t_res             r_res, n_res;

    logic             out_load;
    logic             drop;
    logic             emit_pix;
    logic [7:0]       src_val;
    logic [CNT_W-1:0] rest;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic [1:0]       plane_inc;
    logic [1:0]       nplanes;
    logic             col_end;
    logic             plane_end;
    logic             row_end;

    assign out_load = !r_ov || i_ready;
    assign drop     = r_finished || r_error || (i_cfg.width == '0) || (i_cfg.height == '0);
    assign o_pop    = !r_busy && !r_bad && i_q_valid && (drop || out_load);
    assign emit_pix = out_load && !r_bad && (r_busy || (i_q_valid && !drop));
    assign src_val  = r_busy ? r_val : i_q_cmd.value;
    assign rest     = (r_busy ? r_left : i_q_cmd.count) - CNT_W'(1);

    // position advance for one pixel
    assign nplanes   = i_cfg.three_planes ? 2'd3 : 2'd1;
    assign col_inc   = r_col + DIM_W'(1);
    assign plane_inc = r_plane + 2'd1;
    assign row_inc   = r_row + DIM_W'(1);
    assign col_end   = (col_inc >= i_cfg.width);
    assign plane_end = (plane_inc >= nplanes);
    assign row_end   = (row_inc >= i_cfg.height);

    // next state and result
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_plane    = r_plane;
        n_finished = r_finished;
        n_error    = r_error;
        n_busy     = r_busy;
        n_bad      = r_bad;
        n_val      = r_val;
        n_left     = r_left;
        n_ov       = r_ov && !i_ready;
        n_res      = r_res;
        if (out_load && r_bad) begin
            n_bad   = 1'b0;
            n_error = 1'b1;
            n_ov    = 1'b1;
            n_res   = '{column: '0, row: '0, plane: '0, value: '0,
                        malformed: 1'b1, complete: 1'b0, last: 1'b1};
        end else if (emit_pix) begin
            n_ov      = 1'b1;
            n_res     = '{column: r_col[15:0], row: r_row[15:0], plane: r_plane,
                          value: src_val, malformed: 1'b0, complete: 1'b0,
                          last: (rest == '0)};
            n_col     = col_inc;
            n_val     = src_val;
            n_left    = rest;
            n_busy    = !col_end && (rest != '0);
            n_bad     = col_end && (rest != '0);
            if (col_end) begin
                n_col   = '0;
                n_plane = plane_inc;
                if (plane_end) begin
                    n_plane = 2'd0;
                    n_row   = row_inc;
                    if (row_end) begin
                        n_finished     = 1'b1;
                        n_res.complete = 1'b1;
                    end
                end
            end
        end
    end

    // control and position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_plane    <= '0;
            r_finished <= 1'b0;
            r_error    <= 1'b0;
            r_busy     <= 1'b0;
            r_bad      <= 1'b0;
            r_left     <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_plane    <= n_plane;
            r_finished <= n_finished;
            r_error    <= n_error;
            r_busy     <= n_busy;
            r_bad      <= n_bad;
            r_left     <= n_left;
            r_ov       <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_res <= n_res;
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;

endmodule

### design/pcx_rle_plane_decoder.sv
// top level of the pcx run-length plane decoder: configuration and wiring
// depends on pcxrle_pkg, pcxrle_front, pcxrle_queue, pcxrle_back
//
// channel   direction  transaction
// s_axis    in         one compressed byte
// m_axis    out        one decoded pixel or one malformed-run report
// cfg       in         one register write (index, data)
//
// a literal byte passes the queue and the output register, one per cycle if not stalled
// a run is written one pixel per cycle while not stalled, plus any malformed report
// a marker byte gives nothing itself; the writer loop sets the rate
// reset clears position, run and error state; geometry returns to 1 x 1, one plane
// a two-entry job queue lets input run ahead while the output is stalled
module pcx_rle_plane_decoder
    import pcxrle_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] code_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // [15:0] pixel_column, [31:16] pixel_row,
                                              // [33:32] plane_index, [41:34] pixel_value,
                                              // [47:42] zero
    output logic [1:0]        m_axis_tuser,   // [0] malformed, [1] image_complete
    output logic              m_axis_tlast,   // last_of_input
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    logic accept;
    logic push;
    logic pop;
    logic q_valid;
    logic q_full;
    t_cmd push_cmd;
    t_cmd head_cmd;
    t_res res;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{width: DIM_W'(1), height: DIM_W'(1), three_planes: 1'b0};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_WIDTH:  r_cfg.width        <= i_cfg_data;
                REG_HEIGHT: r_cfg.height       <= i_cfg_data;
                REG_PLANES: r_cfg.three_planes <= i_cfg_data[0];
                default:    r_cfg              <= r_cfg;
            endcase
        end
    end

    pcxrle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .i_dims_zero ((r_cfg.width == '0) || (r_cfg.height == '0)),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    pcxrle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (head_cmd)
    );

    pcxrle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_cmd   (head_cmd),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    // output packing
    assign m_axis_tdata = {6'd0, res.value, res.plane, res.row, res.column};
    assign m_axis_tuser = {res.complete, res.malformed};
    assign m_axis_tlast = res.last;

endmodule

### dv/pcx_rle_pixel_checker.sv
// pixel checker for the pcx run-length plane decoder: watches the byte, pixel and register channels
// predicts every pixel and malformed report, compares in order; depends on pcxrle_pkg
`timescale 1ns / 100ps

module pcx_rle_pixel_checker
    import pcxrle_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  logic [7:0]       i_s_tdata,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    input  logic [47:0]      i_m_tdata,
    input  logic [1:0]       i_m_tuser,
    input  logic             i_m_tlast,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [DIM_W-1:0] i_cfg_data,
    output int               o_fail_cnt,
    output int               o_pending
);

    // geometry as the decoder sees it
    t_cfg             geom;

    // decode position and run state
    logic [DIM_W-1:0] col_pos;
    logic [DIM_W-1:0] row_pos;
    logic [1:0]       plane_pos;
    logic             run_armed;
    logic [CNT_W-1:0] run_cnt;
    logic             image_done;
    logic             error_latched;

    // pixels still owed by the decoder, oldest first
    t_res             pending_pixels_q[$];
    t_res             pixel_batch[0:63];
    int               batch_len;
    t_res             want;
    t_res             got;

    // write one pixel at the current position, then step column, plane and row
    task automatic put_pixel(input logic [7:0] value, output logic line_end);
        t_res       pix;
        logic [1:0] plane_total;
        plane_total = geom.three_planes ? 2'd3 : 2'd1;
        pix         = '0;
        pix.column  = col_pos[15:0];
        pix.row     = row_pos[15:0];
        pix.plane   = plane_pos;
        pix.value   = value;
        line_end    = 1'b0;
        col_pos     = col_pos + 1'b1;
        if (col_pos >= geom.width) begin
            line_end  = 1'b1;
            col_pos   = '0;
            plane_pos = plane_pos + 1'b1;
            if (plane_pos >= plane_total) begin
                plane_pos = '0;
                row_pos   = row_pos + 1'b1;
                if (row_pos >= geom.height) begin
                    image_done   = 1'b1;
                    pix.complete = 1'b1;
                end
            end
        end
        pixel_batch[batch_len] = pix;
        batch_len++;
    endtask

    // work out the results of one compressed byte and queue them
    task automatic decode_code_byte(input logic [7:0] code);
        logic [CNT_W-1:0] left;
        logic             line_end;
        t_res             bad;
        int               k;
        batch_len = 0;
        line_end  = 1'b0;
        if (!(image_done || error_latched || geom.width == '0 || geom.height == '0)) begin
            if (run_armed) begin
                left      = run_cnt;
                run_armed = 1'b0;
                run_cnt   = '0;
                while (left != '0 && !line_end) begin
                    put_pixel(code, line_end);
                    left = left - 1'b1;
                end
                // run went past the line end: report it and stop decoding
                if (left != '0) begin
                    error_latched          = 1'b1;
                    bad                    = '0;
                    bad.malformed          = 1'b1;
                    pixel_batch[batch_len] = bad;
                    batch_len++;
                end
            end else if ((code & MARK_BITS) == MARK_BITS) begin
                run_armed = 1'b1;
                run_cnt   = code[CNT_W-1:0];
            end else begin
                put_pixel(code, line_end);
            end
        end
        if (batch_len > 0) begin
            pixel_batch[batch_len-1].last = 1'b1;
        end
        for (k = 0; k < batch_len; k++) begin
            pending_pixels_q.push_back(pixel_batch[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t ns: %s mismatch: expected 0x%0h actual 0x%0h",
                     $time, name, exp_val, act_val);
            o_fail_cnt++;
        end
    endtask

    // track register writes, predict on accepted bytes, compare accepted pixels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            geom.width         = 17'd1;
            geom.height        = 17'd1;
            geom.three_planes  = 1'b0;
            col_pos            = '0;
            row_pos            = '0;
            plane_pos          = '0;
            run_armed          = 1'b0;
            run_cnt            = '0;
            image_done         = 1'b0;
            error_latched      = 1'b0;
            pending_pixels_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WIDTH:  geom.width        = i_cfg_data;
                    REG_HEIGHT: geom.height       = i_cfg_data;
                    REG_PLANES: geom.three_planes = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_code_byte(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.column    = i_m_tdata[15:0];
                got.row       = i_m_tdata[31:16];
                got.plane     = i_m_tdata[33:32];
                got.value     = i_m_tdata[41:34];
                got.malformed = i_m_tuser[0];
                got.complete  = i_m_tuser[1];
                got.last      = i_m_tlast;
                if (pending_pixels_q.size() == 0) begin
                    $display("%0t ns: unexpected result: expected none actual 0x%0h %0h %0b",
                             $time, i_m_tdata, i_m_tuser, i_m_tlast);
                    o_fail_cnt++;
                end else begin
                    want = pending_pixels_q.pop_front();
                    check_field("pixel_column", want.column, got.column);
                    check_field("pixel_row", want.row, got.row);
                    check_field("plane_index", 16'(want.plane), 16'(got.plane));
                    check_field("pixel_value", 16'(want.value), 16'(got.value));
                    check_field("malformed", 16'(want.malformed), 16'(got.malformed));
                    check_field("image_complete", 16'(want.complete), 16'(got.complete));
                    check_field("last_of_input", 16'(want.last), 16'(got.last));
                end
            end
        end
        o_pending <= pending_pixels_q.size();
    end

endmodule

### dv/pcx_rle_plane_decoder_tb.sv
// testbench top for the pcx run-length plane decoder: clock, reset, byte and register stimulus
// depends on pcxrle_pkg, pcx_rle_plane_decoder and pcx_rle_pixel_checker
`timescale 1ns / 100ps

module pcx_rle_plane_decoder_tb;
    import pcxrle_pkg::*;

    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         SETTLE_CYC  = 16;

    logic             i_clk;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [47:0]      m_axis_tdata;
    logic [1:0]       m_axis_tuser;
    logic             m_axis_tlast;
    logic             i_cfg_valid   = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index   = '0;
    logic [DIM_W-1:0] i_cfg_data    = '0;

    int               fail_cnt;
    int               expect_cnt;
    int               src_idle_pct  = 0;
    int               dst_idle_pct  = 0;
    int               quiet_cycles  = 0;
    int               ph;

    // stimulus-side view of the line, used to keep runs inside it
    logic [DIM_W-1:0] cur_width     = 17'd1;
    logic [DIM_W-1:0] cur_height    = 17'd1;
    logic [DIM_W-1:0] stim_col      = '0;

    logic [DIM_W-1:0] phase_width [0:5] = '{17'd1, 17'd7, 17'd64, 17'd3, 17'd65536, 17'd13};
    logic             phase_three [0:5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    pcx_rle_plane_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    pcx_rle_pixel_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_m_tlast   (m_axis_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (expect_cnt)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // pixel receiver stalls at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("pcx_rle_plane_decoder test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // present one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] code);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // one register write transaction
    task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_WIDTH) cur_width = data;
        if (idx == REG_HEIGHT) cur_height = data;
        @(posedge i_clk);
    endtask

    // stop sending and wait until every owed pixel is out and the block is quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expect_cnt != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    function automatic logic [DIM_W-1:0] room_left();
        return (stim_col < cur_width) ? cur_width - stim_col : 17'd1;
    endfunction

    task automatic advance_col(input int n);
        if (cur_width != '0 && cur_height != '0) begin
            repeat (n) begin
                stim_col = stim_col + 1'b1;
                if (stim_col >= cur_width) stim_col = '0;
            end
        end
    endtask

    task automatic send_literal(input logic [7:0] code);
        send_byte(code);
        advance_col(1);
    endtask

    // marker and data byte; the count is clipped so the run never passes the line end
    task automatic send_run(input int cnt_req, input logic [7:0] value);
        int               cnt;
        logic [DIM_W-1:0] room;
        cnt  = cnt_req;
        room = room_left();
        if (room < cnt) cnt = int'(room);
        send_byte(MARK_BITS | cnt[7:0]);
        send_byte(value);
        advance_col(cnt);
    endtask

    // random mix of literals, runs, empty runs and runs of marker-valued bytes
    task automatic random_bytes(input int n);
        int               made;
        int               pick;
        int               lim;
        logic [DIM_W-1:0] room;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            room = room_left();
            lim  = (room > 63) ? 63 : int'(room);
            if (pick < 55) begin
                send_literal(8'($urandom_range(0, 8'hBF)));
                made += 1;
            end else if (pick < 90) begin
                send_run($urandom_range(1, lim), 8'($urandom_range(0, 255)));
                made += 2;
            end else if (pick < 95) begin
                send_run(0, 8'($urandom_range(0, 255)));
                made += 2;
            end else begin
                send_run($urandom_range(1, lim), 8'($urandom_range(8'hC0, 8'hFF)));
                made += 2;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: literal extremes, short, empty and line-filling runs
        src_idle_pct = 24;
        dst_idle_pct = 78;
        write_reg(REG_WIDTH, 17'd5);
        write_reg(REG_HEIGHT, 17'd65536);
        write_reg(REG_PLANES, 17'd1);
        write_reg(REG_UNUSED, DIM_W'($urandom_range(0, 17'h1FFFF)));
        send_literal(8'h00);
        send_literal(8'hBF);
        send_literal(8'h7F);
        send_literal(8'h80);
        send_literal(8'h3F);
        send_literal(8'h40);
        send_run(2, 8'hC5);
        send_run(0, 8'h12);
        send_run(63, 8'hAA);
        send_run(1, 8'hFF);

        // longest run on a wide line
        settle();
        write_reg(REG_WIDTH, 17'd65536);
        send_run(63, 8'hFF);
        send_literal(8'h01);

        // zero width, then zero height: bytes give nothing and leave the position alone
        settle();
        write_reg(REG_WIDTH, '0);
        send_literal(8'h55);
        send_run(4, 8'h33);
        settle();
        write_reg(REG_WIDTH, 17'h1FFFF);
        write_reg(REG_HEIGHT, '0);
        send_literal(8'h66);
        send_run(2, 8'h77);
        settle();
        write_reg(REG_HEIGHT, 17'h1FFFF);
        send_literal(8'h15);

        // random phases over several geometries and idling patterns
        for (ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                src_idle_pct = 24;
                dst_idle_pct = 78;
            end else if (ph < 4) begin
                src_idle_pct = 78;
                dst_idle_pct = 24;
            end else begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
            settle();
            write_reg(REG_WIDTH, phase_width[ph]);
            write_reg(REG_PLANES, DIM_W'(phase_three[ph]));
            write_reg(REG_HEIGHT, (ph % 2 == 1) ? 17'h1FFFF : 17'd65536);
            random_bytes(64);
        end

        // finish the image with a run past the line end, then trailing bytes
        settle();
        write_reg(REG_PLANES, 17'd0);
        write_reg(REG_WIDTH, 17'd4);
        write_reg(REG_HEIGHT, 17'd1);
        send_byte(8'hFF);
        send_byte(8'h9C);
        send_byte(8'h21);
        send_byte(8'hC2);
        send_byte(8'h10);
        settle();

        if (fail_cnt == 0 && expect_cnt == 0) begin
            $display("pcx_rle_plane_decoder test passed");
        end else begin
            $display("pcx_rle_plane_decoder test failed");
        end
        $finish;
    end

endmodule
